FILE: hw/rtl/dmcs_pkg.sv
// ----------------------------------------------------------------------------
// dmcs_pkg
// Shared widths, register indexes, access codes and types of the
// direct-mapped cache statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmcs_pkg;

   localparam int ADDR_WIDTH  = 16;
   localparam int MAX_LINES   = 64;
   localparam int LINE_BITS   = $clog2(MAX_LINES);
   localparam int FIELD_WIDTH = 3;
   localparam int FIELD_MIN   = 2;
   localparam int FIELD_MAX   = 6;
   // The smallest offset plus index leaves the widest tag.
   localparam int TAG_WIDTH   = ADDR_WIDTH - 2 * FIELD_MIN;
   localparam int WORDS_WIDTH = 7;
   localparam int COUNT_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_BACK  = 2'd2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [FIELD_WIDTH-1:0] OFFSET_BITS_RESET = 3'd4;
   localparam logic [FIELD_WIDTH-1:0] INDEX_BITS_RESET  = 3'd3;

   typedef logic [ADDR_WIDTH-1:0]      addr_type;
   typedef logic [LINE_BITS-1:0]       line_type;
   typedef logic [TAG_WIDTH-1:0]       tag_type;
   typedef logic [WORDS_WIDTH-1:0]     words_type;
   typedef logic [COUNT_WIDTH-1:0]     count_type;
   typedef logic [FIELD_WIDTH-1:0]     field_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   typedef struct packed {
      tag_type tag;
      logic    dirty;
   } line_entry_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dmcs_channels.sv
// ----------------------------------------------------------------------------
// dmcs channels
// Valid/ready channels of the cache statistics block: access requests,
// responses and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmcs_req_if
   import dmcs_pkg::*;
   ();
   logic     valid;
   logic     ready;
   logic     operation;
   addr_type address;

   modport source (output valid, output operation, output address, input ready);
   modport sink   (input valid, input operation, input address, output ready);
endinterface

interface dmcs_rsp_if
   import dmcs_pkg::*;
   ();
   logic      valid;
   logic      ready;
   logic      hit;
   words_type fetched_words;
   words_type written_words;
   count_type read_hits;
   count_type read_misses;
   count_type write_hits;
   count_type write_misses;
   count_type memory_reads;
   count_type memory_writes;

   modport source (
      output valid, output hit, output fetched_words, output written_words,
      output read_hits, output read_misses, output write_hits,
      output write_misses, output memory_reads, output memory_writes,
      input ready
   );
   modport sink (
      input valid, input hit, input fetched_words, input written_words,
      input read_hits, input read_misses, input write_hits,
      input write_misses, input memory_reads, input memory_writes,
      output ready
   );
endinterface

interface dmcs_csr_if
   import dmcs_pkg::*;
   ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/direct_mapped_cache_stats.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_stats
// Direct-mapped cache tag controller that keeps tag and dirty state per line
// in a synchronous memory and counts hits, misses and memory traffic.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  req_ch    in         operation, address
//  rsp_ch    out        hit, per-access traffic, six saturating counters
//  csr_ch    in         register index, data (ready outside reset)
//
// An access reads the line memory in the accept cycle; its tag and dirty bit
// are checked and written back in the lookup state, which can stall, and no
// new word is taken until that update is done. Reset is synchronous; the line
// valid bits sit in flip-flops and clear in the reset cycle, no clearing pass.
// A response waiting in the output register does not block acceptance, but
// the update cycle holds until that response has been taken.
`default_nettype none

module direct_mapped_cache_stats
   import dmcs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   dmcs_req_if.sink    req_ch,
   dmcs_rsp_if.source  rsp_ch,
   dmcs_csr_if.sink    csr_ch
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   function automatic field_type clamp_field(input field_type v);
      field_type r;
      r = v;
      if (v < field_type'(FIELD_MIN)) r = field_type'(FIELD_MIN);
      else if (v > field_type'(FIELD_MAX)) r = field_type'(FIELD_MAX);
      return r;
   endfunction

   function automatic count_type sat_add(input count_type a, input words_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + (COUNT_WIDTH + 1)'(b);
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   state_type state_ff, state_in;

   field_type offset_bits_ff;
   field_type index_bits_ff;
   logic      write_back_ff;

   line_entry_type line_mem [MAX_LINES];
   line_entry_type mem_rd_ff;
   logic [MAX_LINES-1:0] line_valid_ff;

   logic      op_ff;
   line_type  line_ff;
   tag_type   tag_ff;
   words_type block_ff;

   logic      rsp_valid_ff;
   logic      rsp_hit_ff;
   words_type rsp_fetched_ff;
   words_type rsp_written_ff;

   count_type read_hit_ff, read_miss_ff, write_hit_ff, write_miss_ff;
   count_type mem_read_ff, mem_write_ff;

   logic      req_accept;
   logic      update;
   field_type ob, ib;
   logic [FIELD_WIDTH:0] tag_shift;
   line_type  line_in;
   tag_type   tag_in;
   words_type block_in;

   logic      valid_hit, hit, victim_dirty;
   words_type fetched, written;
   line_entry_type entry_in;

   // ---------------- configuration ----------------
   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RESET;
         index_bits_ff  <= INDEX_BITS_RESET;
         write_back_ff  <= 1'b1;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_OFFSET_BITS: offset_bits_ff <= csr_ch.data;
            CSR_INDEX_BITS:  index_bits_ff  <= csr_ch.data;
            CSR_WRITE_BACK:  write_back_ff  <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // ---------------- address split ----------------
   assign req_ch.ready = !reset && (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      ob        = clamp_field(offset_bits_ff);
      ib        = clamp_field(index_bits_ff);
      tag_shift = {1'b0, ob} + {1'b0, ib};
      line_in   = LINE_BITS'(req_ch.address >> ob)
                  & LINE_BITS'((WORDS_WIDTH'(1) << ib) - WORDS_WIDTH'(1));
      tag_in    = TAG_WIDTH'(req_ch.address >> tag_shift);
      block_in  = WORDS_WIDTH'(1) << ob;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= req_ch.operation;
         line_ff   <= line_in;
         tag_ff    <= tag_in;
         block_ff  <= block_in;
         mem_rd_ff <= line_mem[line_in];
      end
   end

   // ---------------- lookup and update ----------------
   assign update = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      valid_hit    = line_valid_ff[line_ff];
      hit          = valid_hit && (mem_rd_ff.tag == tag_ff);
      victim_dirty = valid_hit && mem_rd_ff.dirty;
      fetched      = '0;
      written      = '0;
      entry_in.tag = tag_ff;
      if (op_ff == OP_READ) begin
         entry_in.dirty = hit ? mem_rd_ff.dirty : 1'b0;
         if (!hit) begin
            fetched = block_ff;
            if (write_back_ff && victim_dirty) written = block_ff;
         end
      end else begin
         entry_in.dirty = 1'b1;
         if (hit) begin
            if (!write_back_ff) written = WORDS_WIDTH'(1);
         end else begin
            fetched = block_ff;
            if (!write_back_ff) written = WORDS_WIDTH'(1);
            else if (victim_dirty) written = block_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update) line_mem[line_ff] <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
      end else if (update) begin
         line_valid_ff[line_ff] <= 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_LOOKUP;
         ST_LOOKUP: if (update) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------- counters ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         read_hit_ff   <= '0;
         read_miss_ff  <= '0;
         write_hit_ff  <= '0;
         write_miss_ff <= '0;
         mem_read_ff   <= '0;
         mem_write_ff  <= '0;
      end else if (update) begin
         if (op_ff == OP_READ) begin
            if (hit) read_hit_ff  <= sat_add(read_hit_ff, WORDS_WIDTH'(1));
            else     read_miss_ff <= sat_add(read_miss_ff, WORDS_WIDTH'(1));
         end else begin
            if (hit) write_hit_ff  <= sat_add(write_hit_ff, WORDS_WIDTH'(1));
            else     write_miss_ff <= sat_add(write_miss_ff, WORDS_WIDTH'(1));
         end
         mem_read_ff  <= sat_add(mem_read_ff, fetched);
         mem_write_ff <= sat_add(mem_write_ff, written);
      end
   end

   // ---------------- response register ----------------
   // The counters only move on an update, which waits for the response
   // register to drain, so they serve directly as the response word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_hit_ff     <= hit;
         rsp_fetched_ff <= fetched;
         rsp_written_ff <= written;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.fetched_words = rsp_fetched_ff;
   assign rsp_ch.written_words = rsp_written_ff;
   assign rsp_ch.read_hits     = read_hit_ff;
   assign rsp_ch.read_misses   = read_miss_ff;
   assign rsp_ch.write_hits    = write_hit_ff;
   assign rsp_ch.write_misses  = write_miss_ff;
   assign rsp_ch.memory_reads  = mem_read_ff;
   assign rsp_ch.memory_writes = mem_write_ff;

`ifndef SYNTHESIS
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted access did not enter lookup");

   a_update_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      update |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("update did not present a response");

   a_miss_fetches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hit_ff == (rsp_fetched_ff == '0)))
      else $error("fetch count disagrees with hit");
`endif

endmodule

`default_nettype wire

FILE: dv/direct_mapped_cache_stats_test.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_stats_test
// Self-checking bench for the cache statistics block. A scripted opening walks
// hits, clean and dirty victims, both write policies and clamped field sizes.
// Random phases then follow with new register settings and local address
// streams. Every response word is checked against a shadow copy of the tags
// and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_cache_stats_test;
   import dmcs_pkg::*;

   localparam int SCRIPT_ROWS    = 25;
   localparam int RANDOM_ITEMS   = 1330;
   localparam int STEADY_ITEMS   = 120;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 1000;

   // Index 3 decodes to no register; writes to it must change nothing.
   localparam csr_index_type CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_ACCESS, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      logic          op;
      addr_type      addr;
      csr_index_type reg_index;
      csr_data_type  reg_data;
      logic          given;
      logic          hit;
      words_type     fetched;
      words_type     written;
   } script_row_type;

   typedef struct {
      logic      given;
      logic      hit;
      words_type fetched;
      words_type written;
   } given_result_type;

   typedef struct {
      logic      hit;
      words_type fetched_words;
      words_type written_words;
      count_type read_hits;
      count_type read_misses;
      count_type write_hits;
      count_type write_misses;
      count_type memory_reads;
      count_type memory_writes;
   } cache_response_type;

   logic clock = 1'b0;
   logic reset;

   dmcs_req_if req_ch ();
   dmcs_rsp_if rsp_ch ();
   dmcs_csr_if csr_ch ();

   direct_mapped_cache_stats dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow of the line store, the counters and the registers.
   tag_type            shadow_tags  [MAX_LINES] = '{default: '0};
   logic               shadow_valid [MAX_LINES] = '{default: 1'b0};
   logic               shadow_dirty [MAX_LINES] = '{default: 1'b0};
   cache_response_type running = '{default: '0};
   field_type          cfg_offset_bits = OFFSET_BITS_RESET;
   field_type          cfg_index_bits  = INDEX_BITS_RESET;
   logic               cfg_write_back  = 1'b1;

   cache_response_type predicted_responses [$];
   given_result_type   given_results [$];
   int                 mismatches = 0;

   // Stimulus side: field sizes as last written, pacing knobs.
   field_type      gen_offset = OFFSET_BITS_RESET;
   field_type      gen_index  = INDEX_BITS_RESET;
   int             req_gap_pct   = 25;
   int             rsp_stall_pct = 25;
   bit             steady_tail   = 1'b0;
   int             stall_left    = 0;
   logic           rsp_ready_ff  = 1'b1;
   int             idle_count    = 0;
   script_row_type script [SCRIPT_ROWS];

   assign rsp_ch.ready = rsp_ready_ff;

   wire req_fire = req_ch.valid && req_ch.ready;
   wire rsp_fire = rsp_ch.valid && rsp_ch.ready;
   wire csr_fire = csr_ch.valid && csr_ch.ready;

   function automatic int unsigned clamp_field(field_type v);
      if (v < FIELD_MIN) return FIELD_MIN;
      if (v > FIELD_MAX) return FIELD_MAX;
      return v;
   endfunction

   function automatic count_type sat_add(count_type a, int unsigned b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + b;
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic cache_response_type predict_access(logic op, addr_type addr);
      int unsigned        ob, ib, blk, line, fetched, written;
      tag_type            tag;
      logic               was_valid, was_dirty, is_hit;
      cache_response_type r;
      ob        = clamp_field(cfg_offset_bits);
      ib        = clamp_field(cfg_index_bits);
      blk       = 32'd1 << ob;
      line      = (32'(addr) >> ob) & ((32'd1 << ib) - 1);
      tag       = tag_type'(32'(addr) >> (ob + ib));
      was_valid = shadow_valid[line];
      was_dirty = shadow_dirty[line];
      is_hit    = was_valid && (shadow_tags[line] == tag);
      fetched   = 0;
      written   = 0;
      if (op == OP_READ) begin
         if (is_hit) begin
            running.read_hits = sat_add(running.read_hits, 1);
         end else begin
            running.read_misses = sat_add(running.read_misses, 1);
            if (cfg_write_back && was_valid && was_dirty) written = blk;
            fetched            = blk;
            shadow_tags[line]  = tag;
            shadow_valid[line] = 1'b1;
            shadow_dirty[line] = 1'b0;
         end
      end else begin
         if (is_hit) begin
            running.write_hits = sat_add(running.write_hits, 1);
            if (!cfg_write_back) written = 1;
         end else begin
            running.write_misses = sat_add(running.write_misses, 1);
            fetched = blk;
            // Write-through ignores the dirty bit and writes the one word.
            if (cfg_write_back) begin
               if (was_valid && was_dirty) written = blk;
            end else begin
               written = 1;
            end
            shadow_tags[line]  = tag;
            shadow_valid[line] = 1'b1;
         end
         shadow_dirty[line] = 1'b1;
      end
      running.memory_reads  = sat_add(running.memory_reads, fetched);
      running.memory_writes = sat_add(running.memory_writes, written);
      r               = running;
      r.hit           = is_hit;
      r.fetched_words = words_type'(fetched);
      r.written_words = words_type'(written);
      return r;
   endfunction

   function automatic void compare_field(string name, longint unsigned want,
                                         longint unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function automatic script_row_type checked_row(logic op, addr_type a, logic h,
                                                  words_type f, words_type w);
      return '{ROW_ACCESS, op, a, CSR_UNUSED, 3'd0, 1'b1, h, f, w};
   endfunction

   function automatic script_row_type plain_row(logic op, addr_type a);
      return '{ROW_ACCESS, op, a, CSR_UNUSED, 3'd0, 1'b0, 1'b0, 7'd0, 7'd0};
   endfunction

   function automatic script_row_type csr_row(csr_index_type idx, csr_data_type d);
      return '{ROW_CSR, OP_READ, 16'h0000, idx, d, 1'b0, 1'b0, 7'd0, 7'd0};
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   // Shadow update and response check, all sampled at the same edge.
   always @(posedge clock) begin
      cache_response_type want;
      given_result_type   note;
      if (!reset) begin
         if (csr_fire) begin
            case (csr_ch.index)
               CSR_OFFSET_BITS: cfg_offset_bits = field_type'(csr_ch.data);
               CSR_INDEX_BITS:  cfg_index_bits  = field_type'(csr_ch.data);
               CSR_WRITE_BACK:  cfg_write_back  = csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_fire) begin
            want = predict_access(req_ch.operation, req_ch.address);
            if (given_results.size() != 0) begin
               note = given_results.pop_front();
               if (note.given) begin
                  want.hit           = note.hit;
                  want.fetched_words = note.fetched;
                  want.written_words = note.written;
               end
            end
            predicted_responses.push_back(want);
         end
         if (rsp_fire) begin
            if (predicted_responses.size() == 0) begin
               mismatches++;
               $display("%0t: response word with nothing expected, actual hit %0d",
                        $time, rsp_ch.hit);
            end else begin
               want = predicted_responses.pop_front();
               compare_field("hit", want.hit, rsp_ch.hit);
               compare_field("fetched_words", want.fetched_words, rsp_ch.fetched_words);
               compare_field("written_words", want.written_words, rsp_ch.written_words);
               compare_field("read_hits", want.read_hits, rsp_ch.read_hits);
               compare_field("read_misses", want.read_misses, rsp_ch.read_misses);
               compare_field("write_hits", want.write_hits, rsp_ch.write_hits);
               compare_field("write_misses", want.write_misses, rsp_ch.write_misses);
               compare_field("memory_reads", want.memory_reads, rsp_ch.memory_reads);
               compare_field("memory_writes", want.memory_writes, rsp_ch.memory_writes);
            end
         end
      end
   end

   // Response back-pressure in bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_ready_ff <= (stall_left == 1);
      end else if (!steady_tail && $urandom_range(0, 99) < rsp_stall_pct) begin
         stall_left   <= $urandom_range(1, 13);
         rsp_ready_ff <= 1'b0;
      end else begin
         rsp_ready_ff <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire || csr_fire) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_access(logic op, addr_type addr, given_result_type note);
      given_results.push_back(note);
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.address   <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic pace_sender();
      if (!steady_tail && $urandom_range(0, 99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (predicted_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, csr_data_type data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_OFFSET_BITS) gen_offset = field_type'(data);
      else if (idx == CSR_INDEX_BITS) gen_index = field_type'(data);
   endtask

   initial begin
      addr_type         recent [8];
      addr_type         a, base;
      given_result_type note;
      int               sent, phase_len, pick;
      int unsigned      ob, ib;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_READ;
      req_ch.address   <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_OFFSET_BITS;
      csr_ch.data      <= '0;

      // Opening rows start from the reset geometry: 16-word blocks, 8 lines.
      script = '{
         checked_row(OP_READ,  16'h0000, 1'b0, 16, 0),
         checked_row(OP_READ,  16'h000F, 1'b1, 0, 0),
         checked_row(OP_WRITE, 16'h0005, 1'b1, 0, 0),
         checked_row(OP_READ,  16'h0080, 1'b0, 16, 16),
         checked_row(OP_WRITE, 16'hFFFF, 1'b0, 16, 0),
         checked_row(OP_WRITE, 16'hFF80, 1'b0, 16, 0),
         checked_row(OP_WRITE, 16'hFFF0, 1'b1, 0, 0),
         checked_row(OP_READ,  16'h0070, 1'b0, 16, 16),
         csr_row(CSR_WRITE_BACK, 3'd0),
         csr_row(CSR_OFFSET_BITS, 3'd0),
         csr_row(CSR_INDEX_BITS, 3'd7),
         csr_row(CSR_UNUSED, 3'd7),
         checked_row(OP_WRITE, 16'h1234, 1'b0, 4, 1),
         checked_row(OP_WRITE, 16'h1234, 1'b1, 0, 1),
         checked_row(OP_READ,  16'h1235, 1'b1, 0, 0),
         checked_row(OP_READ,  16'h0000, 1'b0, 4, 0),
         // Lines made dirty under write-through get written back now.
         csr_row(CSR_WRITE_BACK, 3'd1),
         checked_row(OP_READ,  16'h5234, 1'b0, 4, 4),
         checked_row(OP_WRITE, 16'h5234, 1'b1, 0, 0),
         csr_row(CSR_OFFSET_BITS, 3'd7),
         csr_row(CSR_INDEX_BITS, 3'd1),
         plain_row(OP_READ,  16'h1234),
         plain_row(OP_WRITE, 16'h1200),
         plain_row(OP_READ,  16'hFFFF),
         plain_row(OP_WRITE, 16'h0000)
      };
      for (int i = 0; i < 8; i++) recent[i] = addr_type'($urandom_range(0, 65535));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         if (script[i].kind == ROW_CSR) begin
            wait_for_responses();
            write_register(script[i].reg_index, script[i].reg_data);
         end else begin
            pace_sender();
            note = '{script[i].given, script[i].hit, script[i].fetched, script[i].written};
            send_access(script[i].op, script[i].addr, note);
         end
      end

      note = '{1'b0, 1'b0, 7'd0, 7'd0};
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // Registers change only once every word in flight has come back.
         wait_for_responses();
         if ($urandom_range(0, 2) != 0) begin
            write_register(CSR_OFFSET_BITS, csr_data_type'($urandom_range(0, 7)));
            write_register(CSR_INDEX_BITS, csr_data_type'($urandom_range(0, 7)));
         end
         write_register(CSR_WRITE_BACK, csr_data_type'($urandom_range(0, 7)));
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_UNUSED, csr_data_type'($urandom_range(0, 7)));
         req_gap_pct   = pick_pct();
         rsp_stall_pct = pick_pct();
         ob = clamp_field(gen_offset);
         ib = clamp_field(gen_index);
         phase_len = $urandom_range(60, 160);
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            if (RANDOM_ITEMS - sent <= STEADY_ITEMS) steady_tail = 1'b1;
            pick = $urandom_range(0, 99);
            base = recent[$urandom_range(0, 7)];
            // Mostly the same block again or a conflict on the same line.
            if (pick < 45)
               a = base ^ addr_type'($urandom_range(0, (1 << ob) - 1));
            else if (pick < 75)
               a = base ^ addr_type'($urandom_range(1, 255) << (ob + ib));
            else
               a = addr_type'($urandom_range(0, 65535));
            recent[sent % 8] = a;
            pace_sender();
            send_access(logic'($urandom_range(0, 1)), a, note);
            sent++;
         end
      end

      wait_for_responses();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
